[sv/bft_pkg.sv]
// Shared types and constants of the byte frequency table.
// Holds the sizes, the transaction structs and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package bft_pkg;

    localparam int NUM_SYMBOLS = 256;
    localparam int COUNT_WIDTH = 32;
    localparam int SYM_W       = $clog2(NUM_SYMBOLS);
    localparam int NCAND_W     = $clog2(NUM_SYMBOLS + 1);
    localparam int OUT_COUNT_W = 32;
    localparam int BYTE_W      = 8;

    localparam logic REQ_COUNT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]      symbol_out;
        logic [OUT_COUNT_W-1:0] count_out;
        logic                   last_entry;
        logic                   empty_list;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic count_start;
        logic count_write;
        logic sweep_start;
        logic sweep_step;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_issue;
        logic out_free;
    } t_dp_status;

endpackage

[sv/bft_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/bft_ctrl.sv]
// Controller state machine of the byte frequency table.
// Depends on bft_pkg for the command and status structs.
`timescale 1ns / 1ps

module bft_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_req_type,
    input  bft_pkg::t_dp_status i_status,
    output bft_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_WR,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == bft_pkg::REQ_COUNT) begin
                        o_cmd.count_start = 1'b1;
                        n_state           = ST_CNT_WR;
                    end else begin
                        o_cmd.sweep_start = 1'b1;
                        n_state           = ST_SWEEP;
                    end
                end
            end
            ST_CNT_WR: begin
                o_cmd.count_write = 1'b1;
                n_state           = ST_IDLE;
            end
            ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/bft_datapath.sv]
// Datapath of the byte frequency table: count store, valid marks, readout position,
// minimum search over the store and the output register.
// Depends on bft_pkg and bft_ram.
`timescale 1ns / 1ps

module bft_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bft_pkg::t_dp_cmd             i_cmd,
    output bft_pkg::t_dp_status          o_status,
    input  logic [bft_pkg::BYTE_W-1:0]   i_byte_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bft_pkg::t_out_item           o_out_item
);

    localparam int SW = bft_pkg::SYM_W;
    localparam int CW = bft_pkg::COUNT_WIDTH;

    logic [bft_pkg::NUM_SYMBOLS-1:0] r_valid;
    logic                            r_pass_open;
    logic [CW-1:0]                   r_last_cnt;
    logic [SW-1:0]                   r_last_sym;

    logic [SW-1:0]               r_sym;
    logic                        r_sym_ok;
    logic [SW-1:0]               r_addr;
    logic                        r_rd_pend;
    logic [SW-1:0]               r_rd_addr;
    logic                        r_found;
    logic [SW-1:0]               r_best_sym;
    logic [CW-1:0]               r_best_cnt;
    logic [bft_pkg::NCAND_W-1:0] r_ncand;
    logic                        r_out_valid;
    bft_pkg::t_out_item          r_out;

    logic                             w_rd_en;
    logic [SW-1:0]                    w_rd_addr;
    logic [CW-1:0]                    w_rd_data;
    logic [CW-1:0]                    w_old;
    logic                             w_wr_en;
    logic                             w_after_last;
    logic                             w_cand;
    logic                             w_take;
    logic                             w_empty;
    logic                             w_last;
    logic [bft_pkg::OUT_COUNT_W-1:0]  w_count_sat;

    assign w_rd_en   = i_cmd.count_start || i_cmd.sweep_step;
    assign w_rd_addr = i_cmd.count_start ? i_byte_value[SW-1:0] : r_addr;

    // Entries never written since the last clear read as zero
    assign w_old   = r_valid[r_sym] ? w_rd_data : '0;
    assign w_wr_en = i_cmd.count_write && r_sym_ok && (w_old != '1);

    bft_ram #(
        .WIDTH(CW),
        .DEPTH(bft_pkg::NUM_SYMBOLS)
    ) u_count_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_sym),
        .i_wr_data(w_old + CW'(1)),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    // Entries already read in this pass sort at or below the last one emitted
    assign w_after_last = !r_pass_open || (w_rd_data > r_last_cnt)
                          || ((w_rd_data == r_last_cnt) && (r_rd_addr > r_last_sym));

    // Strict compare keeps ties on the smaller symbol
    assign w_cand = r_rd_pend && r_valid[r_rd_addr] && (w_rd_data != '0) && w_after_last;
    assign w_take = w_cand && (!r_found || (w_rd_data < r_best_cnt));

    assign w_empty = (r_ncand == '0);
    assign w_last  = (r_ncand == bft_pkg::NCAND_W'(1));

    generate
        if (CW > bft_pkg::OUT_COUNT_W) begin : g_sat
            assign w_count_sat = (|r_best_cnt[CW-1:bft_pkg::OUT_COUNT_W]) ? '1
                                 : r_best_cnt[bft_pkg::OUT_COUNT_W-1:0];
        end else begin : g_ext
            assign w_count_sat = bft_pkg::OUT_COUNT_W'(r_best_cnt);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_pass_open <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.sweep_step;
            if (i_cmd.count_start) begin
                r_pass_open <= 1'b0;
            end
            if (w_wr_en) begin
                r_valid[r_sym] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (!w_empty) begin
                    if (w_last) begin
                        r_valid     <= '0;
                        r_pass_open <= 1'b0;
                    end else begin
                        r_pass_open <= 1'b1;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.count_start) begin
            r_sym    <= i_byte_value[SW-1:0];
            r_sym_ok <= ({1'b0, i_byte_value} < (bft_pkg::BYTE_W + 1)'(bft_pkg::NUM_SYMBOLS));
        end
        if (i_cmd.sweep_start) begin
            r_addr  <= '0;
            r_found <= 1'b0;
            r_ncand <= '0;
        end else begin
            if (i_cmd.sweep_step) begin
                r_addr <= r_addr + SW'(1);
            end
            if (w_cand) begin
                r_ncand <= r_ncand + bft_pkg::NCAND_W'(1);
            end
            if (w_take) begin
                r_found    <= 1'b1;
                r_best_sym <= r_rd_addr;
                r_best_cnt <= w_rd_data;
            end
        end
        r_rd_addr <= r_addr;
        if (i_cmd.emit && !w_empty && !w_last) begin
            r_last_cnt <= r_best_cnt;
            r_last_sym <= r_best_sym;
        end
        if (i_cmd.emit) begin
            if (w_empty) begin
                r_out.symbol_out <= '0;
                r_out.count_out  <= '0;
                r_out.last_entry <= 1'b0;
                r_out.empty_list <= 1'b1;
            end else begin
                r_out.symbol_out <= bft_pkg::BYTE_W'(r_best_sym);
                r_out.count_out  <= w_count_sat;
                r_out.last_entry <= w_last;
                r_out.empty_list <= 1'b0;
            end
        end
    end

    assign o_status.last_issue = (r_addr == SW'(bft_pkg::NUM_SYMBOLS - 1));
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_out_item          = r_out;

endmodule

[sv/byte_frequency_table_sorted_core.sv]
// Count transaction: the store is read on acceptance and the counter updated on the next;
// no request is taken during the update. Read transaction: a sweep feeds one count-store
// read per cycle through the minimum search, then the drain and emit states follow; the next
// transaction is taken once the result is loaded into the output register.
// Reset (synchronous, active low) clears all valid marks and the readout pass at once.
// Depends on bft_pkg, bft_ctrl, bft_datapath and bft_ram.
`timescale 1ns / 1ps

module byte_frequency_table_sorted_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bft_pkg::t_in_item  i_in_item,
    // Result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bft_pkg::t_out_item o_out_item
);

    bft_pkg::t_dp_cmd    w_cmd;
    bft_pkg::t_dp_status w_status;

    // Sequence count and read transactions; hold in the emit state until the
    // output register can take the result.
    bft_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_req_type(i_in_item.req_type),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    // Count store with per-entry valid bits, the count and symbol of the last entry
    // emitted in this readout pass, a sweep over all symbols that finds the smallest
    // nonzero entry sorting after it and the number still to go, and the output
    // register that parts the two sides.
    // A count transaction drops any readout pass in progress; the final entry
    // clears the whole store.
    bft_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_byte_value(i_in_item.byte_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[test/tb_byte_frequency_table_sorted_core.sv]
// Self-checking testbench of byte_frequency_table_sorted_core: counts bytes, reads the sorted list.
// Directed table first, then random data sets, checked by an in-bench predictor or typed entries.
// Depends on bft_pkg and byte_frequency_table_sorted_core.
`timescale 1ns / 1ps

module tb_byte_frequency_table_sorted_core;
    import bft_pkg::*;

    // Cycles without any accepted transaction before the run is declared hung. A read
    // waits for a full sweep of the store, plus random stall on either side.
    localparam int unsigned HANG_LIMIT   = 2000;
    // Settling time after the last expected entry has arrived
    localparam int unsigned SETTLE_TIME  = NUM_SYMBOLS + 40;
    localparam int unsigned RANDOM_REQS  = 750;
    localparam int unsigned MAX_WAIT     = 18;

    localparam t_out_item NOTHING_COUNTED = '{symbol_out: '0, count_out: '0,
                                              last_entry: 1'b0, empty_list: 1'b1};

    typedef struct {
        t_in_item  req;
        bit        known;   // entry typed in below rather than predicted
        t_out_item entry;
    } t_plan_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // Predictor state: one counter and one emitted mark per symbol, plus the pass book-keeping
    logic [COUNT_WIDTH-1:0] tally [NUM_SYMBOLS];
    bit                     shown [NUM_SYMBOLS];
    int unsigned            entries_to_go = 0;
    bit                     pass_open     = 1'b0;

    t_out_item   entries_due [$];
    int unsigned reqs_taken  = 0;
    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_calm   = 0;
    int unsigned take_calm   = 0;

    // Directed part: extremes of the byte, empty reads, ties, single-symbol sets and
    // a count that abandons a readout pass half way.
    t_plan_row plan [25] = '{
        '{'{REQ_READ,  8'h00}, 1'b1, NOTHING_COUNTED},        // read straight after reset
        '{'{REQ_COUNT, 8'h00}, 1'b0, '0},
        '{'{REQ_COUNT, 8'hFF}, 1'b0, '0},
        '{'{REQ_COUNT, 8'hFF}, 1'b0, '0},
        '{'{REQ_COUNT, 8'h80}, 1'b0, '0},
        '{'{REQ_READ,  8'hFF}, 1'b1, '{8'h00, 32'd1, 1'b0, 1'b0}}, // tie: smaller symbol first
        '{'{REQ_READ,  8'h00}, 1'b1, '{8'h80, 32'd1, 1'b0, 1'b0}},
        '{'{REQ_READ,  8'h5A}, 1'b1, '{8'hFF, 32'd2, 1'b1, 1'b0}}, // last entry clears store
        '{'{REQ_READ,  8'hFF}, 1'b1, NOTHING_COUNTED},
        '{'{REQ_COUNT, 8'h05}, 1'b0, '0},
        '{'{REQ_COUNT, 8'h05}, 1'b0, '0},
        '{'{REQ_COUNT, 8'h03}, 1'b0, '0},
        '{'{REQ_READ,  8'h00}, 1'b0, '0},
        '{'{REQ_COUNT, 8'h07}, 1'b0, '0},                     // abandons the pass
        '{'{REQ_READ,  8'h00}, 1'b0, '0},
        '{'{REQ_READ,  8'h00}, 1'b0, '0},
        '{'{REQ_READ,  8'h00}, 1'b0, '0},
        '{'{REQ_COUNT, 8'hAA}, 1'b0, '0},
        '{'{REQ_READ,  8'h00}, 1'b0, '0},                     // single symbol: first is last
        '{'{REQ_COUNT, 8'h55}, 1'b0, '0},
        '{'{REQ_COUNT, 8'h01}, 1'b0, '0},
        '{'{REQ_READ,  8'h00}, 1'b0, '0},
        '{'{REQ_COUNT, 8'h01}, 1'b0, '0},                     // abandon, order changes
        '{'{REQ_READ,  8'h00}, 1'b0, '0},
        '{'{REQ_READ,  8'h00}, 1'b0, '0}
    };

    byte_frequency_table_sorted_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Drop the emitted marks and the pass counters; the counts themselves are kept.
    function automatic void end_pass();
        foreach (shown[s]) shown[s] = 1'b0;
        entries_to_go = 0;
        pass_open     = 1'b0;
    endfunction

    // Advance the predictor by one accepted request. Returns 1 when the request produces
    // a sorted entry, which is then left in entry.
    function automatic bit predict_entry(input t_in_item req, output t_out_item entry);
        int unsigned live;
        int          best;
        logic [63:0] wide;
        live  = 0;
        best  = -1;
        entry = '0;
        if (req.req_type == REQ_COUNT) begin
            // A count always abandons a readout pass that is under way
            if (pass_open) end_pass();
            if (req.byte_value < NUM_SYMBOLS && tally[req.byte_value] != '1) begin
                tally[req.byte_value] = tally[req.byte_value] + 1'b1;
            end
            return 1'b0;
        end
        if (!pass_open) begin
            foreach (tally[s]) if (tally[s] != '0) live++;
            if (live == 0) begin
                entry.empty_list = 1'b1;
                return 1'b1;
            end
            entries_to_go = live;
            pass_open     = 1'b1;
        end
        // Strict compare: on equal counts the lower symbol wins
        foreach (tally[s]) begin
            if (tally[s] != '0 && !shown[s] && (best < 0 || tally[s] < tally[best])) best = s;
        end
        if (best < 0) begin
            end_pass();
            entry.empty_list = 1'b1;
            return 1'b1;
        end
        wide             = 64'(tally[best]);
        shown[best]      = 1'b1;
        entries_to_go    = entries_to_go - 1;
        entry.symbol_out = BYTE_W'(best);
        entry.count_out  = (wide > 64'hFFFF_FFFF) ? '1 : wide[OUT_COUNT_W-1:0];
        entry.last_entry = (entries_to_go == 0);
        if (entries_to_go == 0) begin
            foreach (tally[s]) tally[s] = '0;
            end_pass();
        end
        return 1'b1;
    endfunction

    // Draws a random wait bounded by MAX_WAIT, with the odd stretch of back-to-back transactions.
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Present one request, hold it until the block takes it, then log what it should yield.
    task automatic send_req(input t_in_item req, input bit known, input t_out_item typed,
                            output t_out_item entry);
        int unsigned gap;
        bit          yields;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        reqs_taken++;
        yields = predict_entry(req, entry);
        if (known) entry = typed;
        if (yields) entries_due.push_back(entry);
    endtask

    task automatic send_plain(input logic req_type, input logic [BYTE_W-1:0] value,
                              output t_out_item entry);
        send_req('{req_type, value}, 1'b0, '0, entry);
    endtask

    // One random data set: mostly a well-formed count burst followed by a full readout,
    // sometimes a readout cut short by more counts, sometimes plain noise.
    task automatic play_data_set();
        logic [BYTE_W-1:0] pool [40];
        int unsigned       kind;
        int unsigned       pool_n;
        int unsigned       n;
        t_out_item         entry;
        kind   = $urandom_range(0, 9);
        pool_n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
        foreach (pool[k]) pool[k] = BYTE_W'($urandom_range(0, 255));
        if (kind == 8) begin
            // Noise: random requests of either kind, including reads of an empty store
            n = $urandom_range(1, 6);
            repeat (n) send_plain(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                                  entry);
            return;
        end
        n = (pool_n > 6) ? $urandom_range(pool_n, 2 * pool_n) : $urandom_range(1, 24);
        repeat (n) send_plain(REQ_COUNT, pool[$urandom_range(0, pool_n - 1)], entry);
        if (kind >= 6) begin
            // Read part of the list, then count again so the pass is abandoned
            n = $urandom_range(1, 3);
            repeat (n) send_plain(REQ_READ, BYTE_W'($urandom_range(0, 255)), entry);
            n = $urandom_range(1, 6);
            repeat (n) send_plain(REQ_COUNT, pool[$urandom_range(0, pool_n - 1)], entry);
        end
        // Read to the end of the list; an empty flag also ends it
        do send_plain(REQ_READ, BYTE_W'($urandom_range(0, 255)), entry);
        while (!(entry.last_entry || entry.empty_list));
        if ($urandom_range(0, 3) == 0) begin
            send_plain(REQ_READ, BYTE_W'($urandom_range(0, 255)), entry);
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Stimulus: reset, directed table, random data sets, then drain and judge
    initial begin
        t_out_item entry;
        foreach (tally[s]) tally[s] = '0;
        foreach (shown[s]) shown[s] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (plan[r]) send_req(plan[r].req, plan[r].known, plan[r].entry, entry);
        while (reqs_taken < RANDOM_REQS) play_data_set();
        i_in_valid <= 1'b0;
        while (entries_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_byte_frequency_table_sorted_core: PASS");
        end else begin
            $display("tb_byte_frequency_table_sorted_core: FAIL");
        end
        $finish;
    end

    // Result side: stall at random, then take one transaction and compare it field by field
    initial begin
        int unsigned stall;
        t_out_item   want;
        @(posedge i_clk iff i_rst_n === 1'b1);
        forever begin
            stall = draw_wait(take_calm);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (entries_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected entry, expected none, actual %0h", $time, o_out_item);
            end else begin
                want = entries_due.pop_front();
                check_field("symbol_out", 64'(want.symbol_out), 64'(o_out_item.symbol_out));
                check_field("count_out",  64'(want.count_out),  64'(o_out_item.count_out));
                check_field("last_entry", 64'(want.last_entry), 64'(o_out_item.last_entry));
                check_field("empty_list", 64'(want.empty_list), 64'(o_out_item.empty_list));
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= HANG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
                $display("tb_byte_frequency_table_sorted_core: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

[filelist.f]
sv/bft_pkg.sv
sv/bft_ram.sv
sv/bft_ctrl.sv
sv/bft_datapath.sv
sv/byte_frequency_table_sorted_core.sv
test/tb_byte_frequency_table_sorted_core.sv
